FILE: src/mle_pkg.sv
// ----------------------------------------------------------------------------
// Masked line editor package
// Shared widths, codes, character constants and the small helper functions
// used by the line editor and its channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package mle_pkg;

  // Field widths of the channels and registers.
  localparam int FUNC_W   = 3;
  localparam int KEY_W    = 8;
  localparam int STAT_W   = 2;
  localparam int KIND_W   = 2;
  localparam int CHAR_W   = 7;
  localparam int LEN_W    = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 6;

  // Default line capacity.
  localparam int LINE_MAX_DEF = 63;

  // Per-entry parse state for recognising a leading "BYE " command.
  localparam int BYE_W   = 3;
  localparam int ENTRY_W = CHAR_W + BYE_W;

  localparam logic [BYE_W-1:0] BYE_SPACE = 3'd0;  // only spaces so far
  localparam logic [BYE_W-1:0] BYE_B     = 3'd1;
  localparam logic [BYE_W-1:0] BYE_BY    = 3'd2;
  localparam logic [BYE_W-1:0] BYE_BYE   = 3'd3;
  localparam logic [BYE_W-1:0] BYE_ARG   = 3'd4;  // inside the argument
  localparam logic [BYE_W-1:0] BYE_FAIL  = 3'd5;  // not a BYE command

  // Input function codes.
  localparam logic [FUNC_W-1:0] FUNC_START = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_KEY   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_ENTER = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_BKSP  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_ESC   = 3'd4;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_EDIT  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ABORT = 2'd2;

  // Echo kinds.
  localparam logic [KIND_W-1:0] ECHO_NONE    = 2'd0;
  localparam logic [KIND_W-1:0] ECHO_PRINT   = 2'd1;
  localparam logic [KIND_W-1:0] ECHO_ERASE   = 2'd2;
  localparam logic [KIND_W-1:0] ECHO_NEWLINE = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_ALL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BYE_MASK     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STAY_ON_LINE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_ONLY  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_UPPER  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_SHOW    = 3'd6;

  // Character constants.
  localparam logic [KEY_W-1:0]  KEY_LO    = 8'h20;
  localparam logic [KEY_W-1:0]  KEY_HI    = 8'h7E;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 7'h20;
  localparam logic [CHAR_W-1:0] CH_STAR   = 7'h2A;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 7'h39;
  localparam logic [CHAR_W-1:0] CH_UP_B   = 7'h42;
  localparam logic [CHAR_W-1:0] CH_UP_E   = 7'h45;
  localparam logic [CHAR_W-1:0] CH_UP_Y   = 7'h59;
  localparam logic [CHAR_W-1:0] CH_LO_A   = 7'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z   = 7'h7A;
  localparam logic [CHAR_W-1:0] CASE_OFS  = 7'h20;

  // One result item as held in the output register.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [KIND_W-1:0] echo_kind;
    logic [CHAR_W-1:0] echo_char;
    logic [LEN_W-1:0]  erase_count;
    logic [CHAR_W-1:0] line_char;
    logic              line_valid;
    logic              last;
  } res_t;

  // Fold a lower-case letter to upper case.
  function automatic logic [CHAR_W-1:0] fold_up(input logic [CHAR_W-1:0] c);
    if (c >= CH_LO_A && c <= CH_LO_Z) begin
      return c - CASE_OFS;
    end
    return c;
  endfunction

  // Advance the BYE recogniser by one stored character.
  function automatic logic [BYE_W-1:0] bye_step(input logic [BYE_W-1:0]  s,
                                                input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] f;
    logic [BYE_W-1:0]  n;
    f = fold_up(c);
    n = BYE_FAIL;
    case (s)
      BYE_SPACE: begin
        if (c == CH_SPACE) n = BYE_SPACE;
        else if (f == CH_UP_B) n = BYE_B;
      end
      BYE_B:   if (f == CH_UP_Y) n = BYE_BY;
      BYE_BY:  if (f == CH_UP_E) n = BYE_BYE;
      BYE_BYE: if (c == CH_SPACE) n = BYE_ARG;
      BYE_ARG: n = BYE_ARG;
      default: n = BYE_FAIL;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: src/mle_in_if.sv
// ----------------------------------------------------------------------------
// Key event channel
// Valid/ready channel carrying one key event (function code and key byte).
// ----------------------------------------------------------------------------
`default_nettype none

interface mle_in_if;
  import mle_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [KEY_W-1:0]  key_code;

  modport source (output valid, output func, output key_code, input ready);
  modport sink   (input valid, input func, input key_code, output ready);
endinterface

`default_nettype wire

FILE: src/mle_out_if.sv
// ----------------------------------------------------------------------------
// Editor result channel
// Valid/ready channel carrying one result item: status, echo and line data.
// ----------------------------------------------------------------------------
`default_nettype none

interface mle_out_if;
  import mle_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [KIND_W-1:0] echo_kind;
  logic [CHAR_W-1:0] echo_char;
  logic [LEN_W-1:0]  erase_count;
  logic [CHAR_W-1:0] line_char;
  logic              line_valid;
  logic              last;

  modport source (output valid, output status, output echo_kind, output echo_char,
                  output erase_count, output line_char, output line_valid,
                  output last, input ready);
  modport sink   (input valid, input status, input echo_kind, input echo_char,
                  input erase_count, input line_char, input line_valid,
                  input last, output ready);
endinterface

`default_nettype wire

FILE: src/mle_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/masked_line_editor.sv
// ----------------------------------------------------------------------------
// Masked line editor
// Terminal line editor fed one key event per transfer; the line is kept in a
// RAM together with a per-character parse state for the BYE argument mask.
// ----------------------------------------------------------------------------
// Usage:
//   key_in carries one event per transfer (start, key, enter, backspace,
//   escape); res_out returns each event's result items in order, the final
//   one with last set. cfg_we/cfg_index/cfg_data write the seven settings;
//   the user must write them only while the block is idle; it is not checked.
// Timing:
//   An event waits in the input register until the block is idle and the
//   output register is free; its first result is then registered in the
//   output register. A new event is taken only once the held one executes.
//   A backspace on a line of two or more characters passes through a
//   read-back state for the parse state of the new last character, which
//   overlaps the next transfer. Enter on a non-empty line streams the line
//   from the RAM read port, one stored character per cycle while the receiver
//   does not stall. The input register frees itself once its event executes,
//   so one more event is taken while a result still waits on res_out.
// Reset and stall:
//   Reset clears the settings to their defaults, empties and disarms the
//   line; the RAM contents are not cleared. When the receiver stalls, the
//   output register holds its item and execution and readout pause.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_line_editor #(
  parameter int LINE_MAX = mle_pkg::LINE_MAX_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  mle_in_if.sink                               key_in,
  mle_out_if.source                            res_out,
  input  wire logic                            cfg_we,
  input  wire logic [mle_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mle_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mle_pkg::*;

  localparam int ADDR_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_BS   = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;

  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LINE_MAX);

  // Settings.
  logic [LEN_W-1:0] max_len;
  logic             mask_all;
  logic             bye_mask;
  logic             stay_on_line;
  logic             digits_only;
  logic             force_upper;
  logic [LEN_W-1:0] mask_show;

  // Control and data registers.
  logic [1:0]        state, state_next;
  logic              hold_valid, hold_valid_next;
  logic [FUNC_W-1:0] hold_func;
  logic [KEY_W-1:0]  hold_key;
  logic              armed, armed_next;
  logic [LEN_W-1:0]  length, length_next;
  logic [BYE_W-1:0]  cur_bye, cur_bye_next;
  logic [LEN_W-1:0]  rd_idx, rd_idx_next;
  logic              out_valid, out_valid_next;
  res_t              out_res, out_res_next;

  // RAM ports.
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  // Decoded key handling.
  logic              slot_free;
  logic              exec;
  logic [LEN_W-1:0]  lim;
  logic              take;
  logic [CHAR_W-1:0] key_char;
  logic [LEN_W-1:0]  new_len;
  logic [BYE_W-1:0]  bye_new;
  logic [LEN_W-1:0]  shown;
  logic [LEN_W-1:0]  len_m1;
  logic [LEN_W-1:0]  len_m2;

  mle_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (LINE_MAX)
  ) u_line_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len      <= LEN_W'(63);
      mask_all     <= 1'b0;
      bye_mask     <= 1'b0;
      stay_on_line <= 1'b0;
      digits_only  <= 1'b0;
      force_upper  <= 1'b0;
      mask_show    <= LEN_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_LEN:      max_len      <= cfg_data;
        CFG_MASK_ALL:     mask_all     <= cfg_data[0];
        CFG_BYE_MASK:     bye_mask     <= cfg_data[0];
        CFG_STAY_ON_LINE: stay_on_line <= cfg_data[0];
        CFG_DIGITS_ONLY:  digits_only  <= cfg_data[0];
        CFG_FORCE_UPPER:  force_upper  <= cfg_data[0];
        CFG_MASK_SHOW:    mask_show    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake and shared decode.
  assign slot_free    = !out_valid || res_out.ready;
  assign exec         = (state == S_IDLE) && hold_valid && slot_free;
  assign key_in.ready = !hold_valid;

  assign lim      = (max_len > LEN_CAP) ? LEN_CAP : max_len;
  assign key_char = force_upper ? fold_up(hold_key[CHAR_W-1:0]) : hold_key[CHAR_W-1:0];
  assign take     = (hold_key >= KEY_LO) && (hold_key <= KEY_HI) && (length < lim) &&
                    (!digits_only || (key_char >= CH_ZERO && key_char <= CH_NINE));
  assign new_len  = length + LEN_W'(1);
  assign len_m1   = length - LEN_W'(1);
  assign len_m2   = length - LEN_W'(2);
  assign bye_new  = bye_step(cur_bye, key_char);
  assign shown    = (mask_all && length > mask_show) ? mask_show : length;

  // Event execution, backspace read-back and line readout.
  always_comb begin
    state_next      = state;
    hold_valid_next = hold_valid;
    armed_next      = armed;
    length_next     = length;
    cur_bye_next    = cur_bye;
    rd_idx_next     = rd_idx;
    out_valid_next  = out_valid && !res_out.ready;
    out_res_next    = out_res;
    mem_we          = 1'b0;
    mem_waddr       = length[ADDR_W-1:0];
    mem_wdata       = {bye_new, key_char};
    mem_re          = 1'b0;
    mem_raddr       = rd_idx[ADDR_W-1:0];

    if (key_in.valid && key_in.ready) begin
      hold_valid_next = 1'b1;
    end

    unique case (state)
      S_IDLE: begin
        if (exec) begin
          hold_valid_next = 1'b0;
          out_valid_next  = 1'b1;
          out_res_next    = '0;
          out_res_next.last = 1'b1;
          if (hold_func == FUNC_START) begin
            armed_next   = 1'b1;
            length_next  = '0;
            cur_bye_next = BYE_SPACE;
            out_res_next.status = STAT_EDIT;
          end else if (!armed) begin
            out_res_next.status = STAT_DONE;
          end else begin
            case (hold_func)
              FUNC_ENTER: begin
                armed_next = 1'b0;
                out_res_next.status    = STAT_DONE;
                out_res_next.echo_kind = stay_on_line ? ECHO_NONE : ECHO_NEWLINE;
                if (length != '0) begin
                  out_res_next.last = 1'b0;
                  rd_idx_next = '0;
                  mem_re      = 1'b1;
                  mem_raddr   = '0;
                  state_next  = S_RD;
                end
              end
              FUNC_BKSP: begin
                out_res_next.status = STAT_EDIT;
                if (length != '0) begin
                  length_next = len_m1;
                  if (!mask_all || length <= mask_show) begin
                    out_res_next.echo_kind   = ECHO_ERASE;
                    out_res_next.erase_count = LEN_W'(1);
                  end
                  if (length >= LEN_W'(2)) begin
                    mem_re     = 1'b1;
                    mem_raddr  = len_m2[ADDR_W-1:0];
                    state_next = S_BS;
                  end else begin
                    cur_bye_next = BYE_SPACE;
                  end
                end
              end
              FUNC_ESC: begin
                armed_next   = 1'b0;
                length_next  = '0;
                cur_bye_next = BYE_SPACE;
                out_res_next.status      = STAT_ABORT;
                out_res_next.erase_count = shown;
                if (shown != '0) begin
                  out_res_next.echo_kind = ECHO_ERASE;
                end
              end
              FUNC_KEY: begin
                out_res_next.status = STAT_EDIT;
                if (take) begin
                  mem_we       = 1'b1;
                  length_next  = new_len;
                  cur_bye_next = bye_new;
                  if (!mask_all || new_len <= mask_show) begin
                    out_res_next.echo_kind = ECHO_PRINT;
                    if (mask_all || (bye_mask && cur_bye == BYE_ARG)) begin
                      out_res_next.echo_char = CH_STAR;
                    end else begin
                      out_res_next.echo_char = key_char;
                    end
                  end
                end
              end
              default: out_res_next.status = STAT_EDIT;
            endcase
          end
        end
      end
      S_BS: begin
        // The parse state of the new last character is back from the RAM.
        cur_bye_next = mem_rdata[ENTRY_W-1:CHAR_W];
        state_next   = S_IDLE;
      end
      S_RD: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_res_next   = '0;
          out_res_next.status     = STAT_DONE;
          out_res_next.line_char  = mem_rdata[CHAR_W-1:0];
          out_res_next.line_valid = 1'b1;
          out_res_next.last       = (rd_idx == len_m1);
          if (rd_idx == len_m1) begin
            state_next = S_IDLE;
          end else begin
            rd_idx_next = rd_idx + LEN_W'(1);
            mem_re      = 1'b1;
            mem_raddr   = rd_idx_next[ADDR_W-1:0];
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      hold_valid <= 1'b0;
      armed      <= 1'b0;
      length     <= '0;
      cur_bye    <= BYE_SPACE;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      hold_valid <= hold_valid_next;
      armed      <= armed_next;
      length     <= length_next;
      cur_bye    <= cur_bye_next;
      out_valid  <= out_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (key_in.valid && key_in.ready) begin
      hold_func <= key_in.func;
      hold_key  <= key_in.key_code;
    end
    rd_idx  <= rd_idx_next;
    out_res <= out_res_next;
  end

  // Output channel.
  assign res_out.valid       = out_valid;
  assign res_out.status      = out_res.status;
  assign res_out.echo_kind   = out_res.echo_kind;
  assign res_out.echo_char   = out_res.echo_char;
  assign res_out.erase_count = out_res.erase_count;
  assign res_out.line_char   = out_res.line_char;
  assign res_out.line_valid  = out_res.line_valid;
  assign res_out.last        = out_res.last;

  // The line never outgrows the RAM.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    length <= LEN_CAP)
    else $error("line length exceeds capacity");

  // Readout only addresses stored characters.
  a_rd_in_line: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> (rd_idx < length))
    else $error("readout index beyond line end");

  // No character is written while the line is being read out or read back.
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !mem_we)
    else $error("RAM write outside idle state");

  // An event is not consumed while the output register is blocked.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && out_valid && !res_out.ready) |=> hold_valid)
    else $error("event consumed while result stalled");

endmodule

`default_nettype wire
